// File: rtl/core/csr_sparse_matrix_vector_multiply_macros.svh
// Assertion macros for the CSR sparse matrix-vector multiply core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS

// Checked only out of reset.
`define SPMV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spmv: assertion failed");

// Checked at every edge, reset included.
`define SPMV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spmv: assertion failed");

`else

`define SPMV_ASSERT(lbl, clk, rst_n, prop)
`define SPMV_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/core/spmv_pkg.sv
// Shared types and constants of the CSR sparse matrix-vector multiply core.
// No dependencies.
`timescale 1ns / 1ps

package spmv_pkg;

    localparam int unsigned MODE_W = 2;
    localparam int unsigned COL_W  = 10;
    localparam int unsigned VAL_W  = 16;
    localparam int unsigned PROD_W = 32;
    localparam int unsigned ACC_W  = 40;
    localparam int unsigned ROW_W  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 2'd0,
        MODE_NZ   = 2'd1,
        MODE_END  = 2'd2
    } t_mode;

    typedef logic signed [VAL_W-1:0]  t_value;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic   vld;
        t_mode  mode;
        t_value val;
        logic   inr;
    } t_pipe_item;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        t_acc             row_sum;
        logic             saturated;
    } t_result;

endpackage

// File: rtl/core/spmv_stream_if.sv
// Valid/ready stream interfaces for the input items and the row results.
// Depends on spmv_pkg.
`timescale 1ns / 1ps

interface spmv_in_if;
    import spmv_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [COL_W-1:0]    column;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output mode, output column, output value, input ready);
    modport sink   (input valid, input mode, input column, input value, output ready);
endinterface

interface spmv_out_if;
    import spmv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        row_index;
    logic signed [ACC_W-1:0] row_sum;
    logic                    saturated;

    modport source (output valid, output row_index, output row_sum, output saturated,
                    input ready);
    modport sink   (input valid, input row_index, input row_sum, input saturated,
                    output ready);
endinterface

// File: rtl/core/spmv_vec_mem.sv
// Dense vector store: one write port, one read port, registered read data.
// Depends on spmv_pkg.
`timescale 1ns / 1ps

module spmv_vec_mem #(
    parameter int unsigned VEC_DEPTH = 1024,
    localparam int unsigned AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  spmv_pkg::t_value i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output spmv_pkg::t_value o_rdata
);
    import spmv_pkg::*;

    t_value r_mem [VEC_DEPTH];
    t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/spmv_mac.sv
// Multiply-accumulate pipeline: operand stage, product stage, saturating row sum,
// row counter and result register. Depends on spmv_pkg and the macros header.
`timescale 1ns / 1ps
`include "csr_sparse_matrix_vector_multiply_macros.svh"

module spmv_mac #(
    parameter longint unsigned ROW_COUNT_MAX = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spmv_pkg::t_pipe_item i_item,
    input  spmv_pkg::t_value     i_rd_data,
    output logic                 o_in_rdy,
    output logic                 o_out_vld,
    input  logic                 i_out_rdy,
    output spmv_pkg::t_result    o_result
);
    import spmv_pkg::*;

    localparam int unsigned CW = (ROW_COUNT_MAX > 1) ? $clog2(ROW_COUNT_MAX) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(ROW_COUNT_MAX - 1);

    // operand stage
    logic   r_s1_vld;
    t_mode  r_s1_mode;
    t_value r_s1_val;
    logic   r_s1_inr;
    // product stage
    logic   r_s2_vld;
    t_mode  r_s2_mode;
    t_prod  r_s2_prod;
    // row state and result
    t_acc          r_acc, n_acc;
    logic          r_clip, n_clip;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_vld, n_out_vld;
    t_result       r_result, n_result;

    logic   w_out_free, w_s3_fire, w_s3_end, w_s2_free, w_s1_free;
    t_value w_vec;
    t_prod  w_prod;
    logic signed [ACC_W:0] w_sum;

    assign w_out_free = !r_out_vld || i_out_rdy;
    assign w_s3_fire  = r_s2_vld && ((r_s2_mode != MODE_END) || w_out_free);
    assign w_s3_end   = w_s3_fire && (r_s2_mode == MODE_END);
    assign w_s2_free  = !r_s2_vld || w_s3_fire;
    assign w_s1_free  = !r_s1_vld || w_s2_free;
    assign o_in_rdy   = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_vld <= i_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_item.vld) begin
            r_s1_mode <= i_item.mode;
            r_s1_val  <= i_item.val;
            r_s1_inr  <= i_item.inr;
        end
    end

    assign w_vec  = r_s1_inr ? i_rd_data : '0;
    assign w_prod = PROD_W'(r_s1_val) * PROD_W'(w_vec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_free && r_s1_vld) begin
            r_s2_mode <= r_s1_mode;
            r_s2_prod <= w_prod;
        end
    end

    assign w_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_s2_prod);

    always_comb begin
        n_acc     = r_acc;
        n_clip    = r_clip;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && !i_out_rdy;
        n_result  = r_result;
        if (w_s3_fire) begin
            case (r_s2_mode)
                MODE_NZ: begin
                    if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
                        n_acc  = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
                        n_clip = 1'b1;
                    end else begin
                        n_acc = w_sum[ACC_W-1:0];
                    end
                end
                MODE_END: begin
                    n_result.row_index = ROW_W'(r_cnt);
                    n_result.row_sum   = r_acc;
                    n_result.saturated = r_clip;
                    n_out_vld          = 1'b1;
                    n_acc              = '0;
                    n_clip             = 1'b0;
                    n_cnt              = (r_cnt == CNT_LAST) ? '0 : r_cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_clip    <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_clip    <= n_clip;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_out_vld = r_out_vld;
    assign o_result  = r_result;

    `SPMV_ASSERT(a_row_clears, i_clk, i_rst_n, w_s3_end |=> (r_acc == '0) && !r_clip)
    `SPMV_ASSERT(a_out_from_end, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(w_s3_end))
    `SPMV_ASSERT(a_cnt_on_end, i_clk, i_rst_n, (r_cnt != $past(r_cnt)) |-> $past(w_s3_end))
    `SPMV_ASSERT(a_s1_held, i_clk, i_rst_n, r_s1_vld && !w_s2_free |=> r_s1_vld)
    `SPMV_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !r_out_vld && !r_s1_vld && !r_s2_vld)

endmodule

// File: rtl/core/csr_sparse_matrix_vector_multiply.sv
// CSR sparse matrix-vector multiply: vector store plus multiply-accumulate pipeline.
// An end-of-row item passes the operand and product stages into the result register.
// Throughput: 1 item per cycle unless result back-pressure stalls an end of row; vector
// read and 16x16 product each own a stage. Synchronous active-low reset clears pipeline,
// row sum, clip flag, row counter; the vector store is not cleared, empty until loaded.
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply #(
    parameter int unsigned     VEC_DEPTH     = 1024,
    parameter longint unsigned ROW_COUNT_MAX = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spmv_in_if.sink        i_in,
    spmv_out_if.source     o_out
);
    import spmv_pkg::*;

    localparam int unsigned AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

    logic          w_rdy, w_accept, w_in_range, w_we, w_re;
    logic [AW-1:0] w_addr;
    t_value        w_rd_data;
    t_pipe_item    w_item;
    t_result       w_result;

    assign w_accept   = i_in.valid && w_rdy;
    assign i_in.ready = w_rdy;
    assign w_in_range = 32'(i_in.column) < VEC_DEPTH;
    assign w_addr     = AW'(i_in.column);
    assign w_we       = w_accept && (i_in.mode == MODE_LOAD) && w_in_range;
    assign w_re       = w_accept && (i_in.mode == MODE_NZ);

    assign w_item.vld  = w_accept;
    assign w_item.mode = t_mode'(i_in.mode);
    assign w_item.val  = i_in.value;
    assign w_item.inr  = w_in_range;

    spmv_vec_mem #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_vec_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (i_in.value),
        .i_re    (w_re),
        .i_raddr (w_addr),
        .o_rdata (w_rd_data)
    );

    spmv_mac #(
        .ROW_COUNT_MAX (ROW_COUNT_MAX)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (w_item),
        .i_rd_data (w_rd_data),
        .o_in_rdy  (w_rdy),
        .o_out_vld (o_out.valid),
        .i_out_rdy (o_out.ready),
        .o_result  (w_result)
    );

    assign o_out.row_index = w_result.row_index;
    assign o_out.row_sum   = w_result.row_sum;
    assign o_out.saturated = w_result.saturated;

endmodule

// File: sim/tb.sv
// Self-checking testbench for csr_sparse_matrix_vector_multiply: random valid/ready
// traffic on both streams, row results checked against an in-bench prediction.
// Depends on spmv_pkg, spmv_in_if/spmv_out_if and the top-level RTL.
`timescale 1ns / 1ps

module tb;
    import spmv_pkg::*;

    localparam int unsigned     VEC_DEPTH    = 1024;
    localparam longint unsigned ROW_WRAP     = 65536;
    localparam int unsigned     GAP_MAX      = 20;
    localparam int unsigned     RANDOM_ITEMS = 900;
    localparam int unsigned     SAT_RUN      = 520;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COL_W-1:0]  column;
        t_value            value;
    } t_item;

    logic i_clk;
    logic i_rst_n;

    spmv_in_if  in_if ();
    spmv_out_if out_if ();

    csr_sparse_matrix_vector_multiply u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    t_item       pending_items[$];
    t_result     expected_rows[$];
    int unsigned loaded_cols[$];
    bit          col_loaded[VEC_DEPTH];

    // predicted block state
    t_value      vec_shadow[VEC_DEPTH];
    t_acc        row_sum_acc;
    bit          clip_seen;
    longint unsigned row_number;

    int unsigned error_count;
    longint unsigned cycle_count;
    longint unsigned cycle_limit = 64'd50_000_000;
    bit          no_idle;
    logic        in_taken;
    int unsigned in_gap;
    int unsigned out_stall;
    t_item       drive_item;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, GAP_MAX);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 31))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add_item(logic [MODE_W-1:0] m, int unsigned c, logic [VAL_W-1:0] v);
        t_item it;
        it.mode   = m;
        it.column = c[COL_W-1:0];
        it.value  = v;
        pending_items.push_back(it);
    endfunction

    function automatic void load(int unsigned c, logic [VAL_W-1:0] v);
        if (!col_loaded[c]) begin
            col_loaded[c] = 1'b1;
            loaded_cols.push_back(c);
        end
        add_item(MODE_LOAD, c, v);
    endfunction

    function automatic void nz(int unsigned c, logic [VAL_W-1:0] v);
        add_item(MODE_NZ, c, v);
    endfunction

    function automatic void end_row();
        add_item(MODE_END, $urandom_range(0, VEC_DEPTH - 1), VAL_W'($urandom_range(0, 65535)));
    endfunction

    function automatic int unsigned pick_loaded();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    // multiply-accumulate prediction for one accepted transfer
    function automatic void accumulate_item(t_item it);
        longint  sum;
        t_result res;
        case (it.mode)
            MODE_LOAD: vec_shadow[it.column] = it.value;
            MODE_NZ: begin
                sum = longint'(row_sum_acc) + longint'(it.value) * longint'(vec_shadow[it.column]);
                if (sum > longint'(ACC_MAX)) begin
                    sum       = longint'(ACC_MAX);
                    clip_seen = 1'b1;
                end else if (sum < longint'(ACC_MIN)) begin
                    sum       = longint'(ACC_MIN);
                    clip_seen = 1'b1;
                end
                row_sum_acc = sum[ACC_W-1:0];
            end
            MODE_END: begin
                res.row_index = row_number[ROW_W-1:0];
                res.row_sum   = row_sum_acc;
                res.saturated = clip_seen;
                expected_rows.push_back(res);
                row_sum_acc = '0;
                clip_seen   = 1'b0;
                row_number++;
                if (row_number >= ROW_WRAP) row_number = 0;
            end
            default: ;
        endcase
    endfunction

    // driver: input stream
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (in_gap != 0) begin
                in_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                drive_item = pending_items.pop_front();
                in_if.mode   <= drive_item.mode;
                in_if.column <= drive_item.column;
                in_if.value  <= drive_item.value;
                in_if.valid  <= 1'b1;
                in_gap = pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // driver: result backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (out_stall != 0) begin
            out_stall--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_row;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected row result: row_index %0d", out_if.row_index);
                    error_count++;
                end else begin
                    exp_row = expected_rows.pop_front();
                    if (out_if.row_index !== exp_row.row_index) begin
                        $error("row_index: expected %0d, got %0d",
                               exp_row.row_index, out_if.row_index);
                        error_count++;
                    end
                    if (out_if.row_sum !== exp_row.row_sum) begin
                        $error("row_sum: expected %0d, got %0d",
                               exp_row.row_sum, out_if.row_sum);
                        error_count++;
                    end
                    if (out_if.saturated !== exp_row.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               exp_row.saturated, out_if.saturated);
                        error_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) accumulate_item(t_item'({in_if.mode, in_if.column,
                                                                     in_if.value}));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0) no_idle <= ($urandom_range(0, 3) == 0);
        if (cycle_count > cycle_limit) begin
            $display("csr_sparse_matrix_vector_multiply test failed");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned k;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.mode   = '0;
        in_if.column = '0;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        in_taken     = 1'b0;
        in_gap       = 0;
        out_stall    = 0;
        no_idle      = 1'b0;
        cycle_count  = 0;
        error_count  = 0;
        row_sum_acc  = '0;
        clip_seen    = 1'b0;
        row_number   = 0;

        // directed: extremes, empty row, ignored mode, reload
        load(0, 16'h8000);
        load(1023, 16'h7FFF);
        load(1, 16'h0100);
        load(2, 16'hFFFF);
        load(512, 16'h0000);
        end_row();
        nz(1, 16'h0100);
        nz(0, 16'h7FFF);
        nz(1023, 16'h8000);
        nz(512, 16'h1234);
        end_row();
        nz(2, 16'hFFFF);
        nz(0, 16'h8000);
        end_row();
        add_item(MODE_NONE, 1023, 16'h7FFF);
        add_item(MODE_NONE, 0, 16'h0000);
        load(1, 16'h8001);
        nz(1, 16'h7FFF);
        end_row();

        // clip high, then step back below the limit; flag must stay set
        repeat (SAT_RUN) nz(0, 16'h8000);
        nz(1023, 16'h8000);
        end_row();
        // clip low
        repeat (SAT_RUN) nz(0, 16'h7FFF);
        end_row();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                load($urandom_range(0, VEC_DEPTH - 1), rand_value());
                n++;
            end else if (k < 14) begin
                add_item(MODE_NONE, $urandom_range(0, VEC_DEPTH - 1),
                         VAL_W'($urandom_range(0, 65535)));
            end else begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                repeat (k) begin
                    if ($urandom_range(0, 15) == 0)
                        load($urandom_range(0, VEC_DEPTH - 1), rand_value());
                    else
                        nz(pick_loaded(), rand_value());
                end
                end_row();
                n += k + 1;
            end
        end

        cycle_limit = longint'(pending_items.size() + 100) * (2 * GAP_MAX + 8) * 3 + 10_000;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_if.valid) @(posedge i_clk);
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("csr_sparse_matrix_vector_multiply test passed");
        end else begin
            $display("csr_sparse_matrix_vector_multiply test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/spmv_pkg.sv
rtl/core/spmv_stream_if.sv
rtl/core/spmv_vec_mem.sv
rtl/core/spmv_mac.sv
rtl/core/csr_sparse_matrix_vector_multiply.sv
sim/tb.sv
